// ===== design/psc_pkg.sv =====
// Shared types and constants for the pump schedule controller.
`default_nettype none

package psc_pkg;

  localparam int CODE_W   = 12;
  localparam int PCT_W    = 7;
  localparam int TIME_W   = 32;
  localparam int RUN_W    = 12;
  localparam int PERIOD_W = 11;
  localparam int MUL_W    = 19;
  localparam int NUM_W    = 20;
  localparam int DEN_W    = 13;
  localparam int STEP_W   = 5;
  localparam int PMS_W    = 27;
  localparam int RMS_W    = 22;

  localparam logic [PCT_W-1:0]  PCT_FULL   = 7'd100;
  localparam logic [15:0]       MS_PER_MIN = 16'd60000;
  localparam logic [9:0]        MS_PER_S   = 10'd1000;
  localparam logic [STEP_W-1:0] DIV_LAST   = 5'd19;

  localparam logic [CODE_W-1:0]   RST_LEVEL_EMPTY = 12'd600;
  localparam logic [CODE_W-1:0]   RST_LEVEL_FULL  = 12'd3500;
  localparam logic [CODE_W-1:0]   RST_RAIN_DRY    = 12'd3000;
  localparam logic [CODE_W-1:0]   RST_RAIN_WET    = 12'd1200;
  localparam logic [PCT_W-1:0]    RST_LOW_LIMIT   = 7'd20;
  localparam logic [PCT_W-1:0]    RST_RAIN_LIMIT  = 7'd60;
  localparam logic [RUN_W-1:0]    RST_RUN_LENGTH  = 12'd10;
  localparam logic [PERIOD_W-1:0] RST_PERIOD      = 11'd30;

  typedef enum logic [2:0] {
    REG_LEVEL_EMPTY = 3'd0,
    REG_LEVEL_FULL  = 3'd1,
    REG_RAIN_DRY    = 3'd2,
    REG_RAIN_WET    = 3'd3,
    REG_LOW_LIMIT   = 3'd4,
    REG_RAIN_LIMIT  = 3'd5,
    REG_RUN_LENGTH  = 3'd6,
    REG_PERIOD      = 3'd7
  } reg_idx_t;

  typedef enum logic {
    CMD_SAMPLE  = 1'b0,
    CMD_CONTROL = 1'b1
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_PCT,
    ST_CTRL
  } state_t;

  typedef struct packed {
    logic capture;
    logic div_load;
    logic div_step;
    logic pct_update;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_control;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/psc_div.sv =====
// Restoring divider, one quotient bit per step.
`default_nettype none

module psc_div (
  input  wire logic                      clk,
  input  wire logic                      load,
  input  wire logic                      step,
  input  wire logic [psc_pkg::NUM_W-1:0] dividend,
  input  wire logic [psc_pkg::DEN_W-1:0] divisor,
  output logic      [psc_pkg::NUM_W-1:0] quotient
);

  logic [psc_pkg::NUM_W-1:0] dvd;
  logic [psc_pkg::DEN_W-1:0] rem;
  logic [psc_pkg::DEN_W-1:0] dvs;
  logic [psc_pkg::DEN_W:0]   trial;
  logic [psc_pkg::DEN_W:0]   diff;
  logic                      ge;

  assign trial = {rem, dvd[psc_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (load) begin
      dvd <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (step) begin
      dvd <= {dvd[psc_pkg::NUM_W-2:0], ge};
      rem <= ge ? diff[psc_pkg::DEN_W-1:0] : trial[psc_pkg::DEN_W-1:0];
    end
  end

  assign quotient = dvd;

endmodule

`default_nettype wire

// ===== design/psc_datapath.sv =====
// Datapath: config registers, percent mapping, pump state and result register.
`default_nettype none

module psc_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_addr,
  input  wire logic [11:0]         cfg_wdata,
  input  wire logic [63:0]         s_axis_tdata,
  input  wire logic [0:0]          s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic      [55:0]         m_axis_tdata,
  input  wire psc_pkg::dp_cmd_t    cmd,
  output psc_pkg::dp_status_t      status
);

  // configuration
  logic [psc_pkg::CODE_W-1:0]   lvl_empty, lvl_full, rn_at0, rn_at100;
  logic [psc_pkg::PCT_W-1:0]    low_limit, rain_limit;
  logic [psc_pkg::RUN_W-1:0]    run_len;
  logic [psc_pkg::PERIOD_W-1:0] period;

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_empty  <= psc_pkg::RST_LEVEL_EMPTY;
      lvl_full   <= psc_pkg::RST_LEVEL_FULL;
      rn_at0     <= psc_pkg::RST_RAIN_DRY;
      rn_at100   <= psc_pkg::RST_RAIN_WET;
      low_limit  <= psc_pkg::RST_LOW_LIMIT;
      rain_limit <= psc_pkg::RST_RAIN_LIMIT;
      run_len    <= psc_pkg::RST_RUN_LENGTH;
      period     <= psc_pkg::RST_PERIOD;
    end else if (cfg_we) begin
      case (psc_pkg::reg_idx_t'(cfg_addr))
        psc_pkg::REG_LEVEL_EMPTY: lvl_empty  <= cfg_wdata;
        psc_pkg::REG_LEVEL_FULL:  lvl_full   <= cfg_wdata;
        psc_pkg::REG_RAIN_DRY:    rn_at0     <= cfg_wdata;
        psc_pkg::REG_RAIN_WET:    rn_at100   <= cfg_wdata;
        psc_pkg::REG_LOW_LIMIT:   low_limit  <= cfg_wdata[psc_pkg::PCT_W-1:0];
        psc_pkg::REG_RAIN_LIMIT:  rain_limit <= cfg_wdata[psc_pkg::PCT_W-1:0];
        psc_pkg::REG_RUN_LENGTH:  run_len    <= cfg_wdata;
        psc_pkg::REG_PERIOD:      period     <= cfg_wdata[psc_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [psc_pkg::CODE_W-1:0] in_level, in_rain;
  logic [psc_pkg::TIME_W-1:0] in_now;
  logic                       in_manual, in_request;
  logic [psc_pkg::PMS_W-1:0]  period_ms;
  logic [psc_pkg::RMS_W-1:0]  run_ms;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_level   <= s_axis_tdata[11:0];
      in_rain    <= s_axis_tdata[23:12];
      in_now     <= s_axis_tdata[55:24];
      in_manual  <= s_axis_tdata[56];
      in_request <= s_axis_tdata[57];
      period_ms  <= psc_pkg::PMS_W'(period) * psc_pkg::PMS_W'(psc_pkg::MS_PER_MIN);
      run_ms     <= psc_pkg::RMS_W'(run_len) * psc_pkg::RMS_W'(psc_pkg::MS_PER_S);
    end
  end

  // percent mapping operands
  logic [psc_pkg::CODE_W:0]   lvl_diff, lvl_span, rn_diff, rn_span;
  logic [psc_pkg::CODE_W-1:0] lvl_dabs, lvl_sabs, rn_dabs, rn_sabs;
  logic [psc_pkg::MUL_W-1:0]  lvl_num, rn_num;
  logic [psc_pkg::NUM_W-1:0]  lvl_dvd, rn_dvd;
  logic [psc_pkg::NUM_W-1:0]  lvl_quo, rn_quo;
  logic                       lvl_zero, rn_zero;

  assign lvl_diff = {1'b0, in_level} - {1'b0, lvl_empty};
  assign lvl_span = {1'b0, lvl_full} - {1'b0, lvl_empty};
  assign rn_diff  = {1'b0, in_rain} - {1'b0, rn_at0};
  assign rn_span  = {1'b0, rn_at100} - {1'b0, rn_at0};

  assign lvl_dabs = lvl_diff[psc_pkg::CODE_W] ? psc_pkg::CODE_W'(-lvl_diff)
                                              : lvl_diff[psc_pkg::CODE_W-1:0];
  assign lvl_sabs = lvl_span[psc_pkg::CODE_W] ? psc_pkg::CODE_W'(-lvl_span)
                                              : lvl_span[psc_pkg::CODE_W-1:0];
  assign rn_dabs  = rn_diff[psc_pkg::CODE_W] ? psc_pkg::CODE_W'(-rn_diff)
                                             : rn_diff[psc_pkg::CODE_W-1:0];
  assign rn_sabs  = rn_span[psc_pkg::CODE_W] ? psc_pkg::CODE_W'(-rn_span)
                                             : rn_span[psc_pkg::CODE_W-1:0];

  assign lvl_num = psc_pkg::MUL_W'(lvl_dabs) * psc_pkg::MUL_W'(psc_pkg::PCT_FULL);
  assign rn_num  = psc_pkg::MUL_W'(rn_dabs) * psc_pkg::MUL_W'(psc_pkg::PCT_FULL);

  // (2*num + den) / (2*den) rounds half away from zero
  assign lvl_dvd = {lvl_num, 1'b0} + psc_pkg::NUM_W'(lvl_sabs);
  assign rn_dvd  = {rn_num, 1'b0} + psc_pkg::NUM_W'(rn_sabs);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      lvl_zero <= (lvl_sabs == '0) || (lvl_diff[psc_pkg::CODE_W] != lvl_span[psc_pkg::CODE_W]);
      rn_zero  <= (rn_sabs == '0) || (rn_diff[psc_pkg::CODE_W] != rn_span[psc_pkg::CODE_W]);
    end
  end

  psc_div u_lvl_div (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (lvl_dvd),
    .divisor  ({lvl_sabs, 1'b0}),
    .quotient (lvl_quo)
  );

  psc_div u_rn_div (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (rn_dvd),
    .divisor  ({rn_sabs, 1'b0}),
    .quotient (rn_quo)
  );

  logic [psc_pkg::PCT_W-1:0] lvl_pct, rn_pct;

  always_comb begin
    if (lvl_zero) begin
      lvl_pct = '0;
    end else if (lvl_quo > psc_pkg::NUM_W'(psc_pkg::PCT_FULL)) begin
      lvl_pct = psc_pkg::PCT_FULL;
    end else begin
      lvl_pct = lvl_quo[psc_pkg::PCT_W-1:0];
    end
    if (rn_zero) begin
      rn_pct = '0;
    end else if (rn_quo > psc_pkg::NUM_W'(psc_pkg::PCT_FULL)) begin
      rn_pct = psc_pkg::PCT_FULL;
    end else begin
      rn_pct = rn_quo[psc_pkg::PCT_W-1:0];
    end
  end

  // block state
  logic [psc_pkg::PCT_W-1:0]  tank_level, wet_pct;
  logic                       low_flag, rain_flag, pump;
  logic [psc_pkg::TIME_W-1:0] stop_time, last_start, cycle_count;

  logic                       pump_next, started;
  logic [psc_pkg::TIME_W-1:0] stop_time_next, last_start_next, cycle_count_next;
  logic [psc_pkg::TIME_W-1:0] since_stop, since_start;
  logic                       stop_hit, pump_kept, due;

  assign since_stop  = in_now - stop_time;
  assign since_start = in_now - last_start;
  assign stop_hit    = pump && (stop_time != '0) && !since_stop[psc_pkg::TIME_W-1];
  assign pump_kept   = pump && !stop_hit && !rain_flag;
  assign due         = (last_start == '0) || (since_start >= psc_pkg::TIME_W'(period_ms));

  always_comb begin
    pump_next        = pump;
    stop_time_next   = stop_time;
    last_start_next  = last_start;
    cycle_count_next = cycle_count;
    started          = 1'b0;
    if (low_flag) begin
      if (pump) begin
        pump_next      = 1'b0;
        stop_time_next = '0;
      end
    end else if (in_manual) begin
      pump_next = in_request;
    end else if (!pump_kept && !rain_flag && due) begin
      pump_next        = 1'b1;
      stop_time_next   = in_now + psc_pkg::TIME_W'(run_ms);
      last_start_next  = in_now;
      cycle_count_next = cycle_count + psc_pkg::TIME_W'(1);
      started          = 1'b1;
    end else if (pump && !pump_kept) begin
      pump_next      = 1'b0;
      stop_time_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tank_level  <= '0;
      wet_pct     <= '0;
      low_flag    <= 1'b0;
      rain_flag   <= 1'b0;
      pump        <= 1'b0;
      stop_time   <= '0;
      last_start  <= '0;
      cycle_count <= '0;
    end else begin
      if (cmd.pct_update) begin
        tank_level <= lvl_pct;
        wet_pct    <= rn_pct;
        low_flag   <= lvl_pct <= low_limit;
        rain_flag  <= rn_pct >= rain_limit;
      end
      if (cmd.commit) begin
        pump        <= pump_next;
        stop_time   <= stop_time_next;
        last_start  <= last_start_next;
        cycle_count <= cycle_count_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_axis_tdata <= {6'd0, cycle_count_next, started, rain_flag, low_flag,
                       wet_pct, tank_level, pump_next};
    end
  end

  assign status.in_control = (psc_pkg::cmd_code_t'(s_axis_tuser[0]) == psc_pkg::CMD_CONTROL);
  assign status.out_free   = !m_axis_tvalid || m_axis_tready;

endmodule

`default_nettype wire

// ===== design/psc_ctrl.sv =====
// Controller state machine sequencing capture, division, flags and commit.
`default_nettype none

module psc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire psc_pkg::dp_status_t status,
  output psc_pkg::dp_cmd_t         cmd
);

  psc_pkg::state_t             state, state_next;
  logic [psc_pkg::STEP_W-1:0]  step_cnt, step_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= psc_pkg::ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    case (state)
      psc_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = status.in_control ? psc_pkg::ST_CTRL : psc_pkg::ST_LOAD;
        end
      end
      psc_pkg::ST_LOAD: begin
        step_cnt_next = '0;
        state_next    = psc_pkg::ST_DIV;
      end
      psc_pkg::ST_DIV: begin
        step_cnt_next = step_cnt + psc_pkg::STEP_W'(1);
        if (step_cnt == psc_pkg::DIV_LAST) begin
          state_next = psc_pkg::ST_PCT;
        end
      end
      psc_pkg::ST_PCT: begin
        state_next = psc_pkg::ST_CTRL;
      end
      psc_pkg::ST_CTRL: begin
        if (status.out_free) begin
          state_next = psc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = psc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd           = '0;
    s_axis_tready = 1'b0;
    case (state)
      psc_pkg::ST_IDLE: begin
        s_axis_tready = !rst;
        cmd.capture   = s_axis_tvalid && !rst;
      end
      psc_pkg::ST_LOAD: cmd.div_load   = 1'b1;
      psc_pkg::ST_DIV:  cmd.div_step   = 1'b1;
      psc_pkg::ST_PCT:  cmd.pct_update = 1'b1;
      psc_pkg::ST_CTRL: cmd.commit     = status.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/pump_schedule_controller.sv =====
// Top level of the pump schedule controller.
//
// Input channel s_axis: one item per step, tuser carries the command (sample
// then control, or control only with the stored readings), tdata the readings,
// millisecond time and manual mode controls. Output channel m_axis: exactly one
// result item per input item, in order.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr.
// A sample item runs through operand load, 20 restoring division steps for both
// percents in parallel, flag update and commit before its result is valid; a
// control-only item goes straight to commit. The next item is accepted the
// cycle after the result is loaded, so no new item is taken while one is being
// worked on; sample throughput is bounded by the bit-serial dividers.
// The result sits in an output register; a new item is accepted and worked
// on while it waits. If the receiver still stalls when the next result is
// ready, the block holds it in its final step and takes no new item.
// Reset (rst, synchronous) restores the configuration defaults, clears the
// percents, flags, pump, timers and cycle count, and empties the output; no
// item is taken while rst is high.
`default_nettype none

module pump_schedule_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [11:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // level_code[11:0], rain_code[23:12], now_ms[55:24], manual_mode[56],
  // manual_request[57], zero[63:58]
  input  wire logic [63:0] s_axis_tdata,
  // cmd[0]
  input  wire logic [0:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // pump_on[0], tank_percent[7:1], wet_percent[14:8], tank_lockout[15],
  // rain_seen[16], cycle_started[17], cycles_run[49:18], zero[55:50]
  output logic      [55:0] m_axis_tdata
);

  psc_pkg::dp_cmd_t    cmd;
  psc_pkg::dp_status_t status;

  psc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  psc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

`default_nettype wire
